/* sv/ybef_pkg.sv */
`default_nettype none

package ybef_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TRIG_W          = 16;
    localparam int TRIG_FRAC       = 14;
    localparam int CFG_INDEX_W     = 3;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index REG_CENTER_X   = 3'd0;
    localparam t_cfg_index REG_CENTER_Y   = 3'd1;
    localparam t_cfg_index REG_CENTER_Z   = 3'd2;
    localparam t_cfg_index REG_YAW_COSINE = 3'd3;
    localparam t_cfg_index REG_YAW_SINE   = 3'd4;

    localparam logic signed [TRIG_W-1:0] TRIG_ONE     = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] TRIG_NEG_ONE = -16'sd16384;

    // clamp a raw trig register to +-1.0 in Q1.14
    function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic [TRIG_W-1:0] raw);
        logic signed [TRIG_W-1:0] v;
        v = $signed(raw);
        if (v > TRIG_ONE) begin
            return TRIG_ONE;
        end else if (v < TRIG_NEG_ONE) begin
            return TRIG_NEG_ONE;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/yaw_box_extent_fit_core.sv */
`default_nettype none
// a last point reaches the output after its transaction through the input, difference,
//   product, projection, tracker, midpoint, product and result registers
// throughput: one point per cycle while the pipeline is not stalled; the min/max trackers update once per valid point
// the pipeline stalls only while a result waits on the output and another result is next
// reset (synchronous, active low) clears valids, trackers and config to center 0, yaw 0
module yaw_box_extent_fit_core #(
    parameter int COORD_WIDTH = ybef_pkg::COORD_WIDTH_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire [ybef_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire [COORD_WIDTH-1:0]                 i_cfg_data,
    input  wire                                   i_s_tvalid,
    output logic                                  o_s_tready,
    // point_x, point_y, point_z from bit 0 up, zero padded
    input  wire [((3*COORD_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    input  wire                                   i_s_tlast,
    output logic                                  o_m_tvalid,
    input  wire                                   i_m_tready,
    // new_center_x, new_center_y, new_center_z, extent_along_x, extent_along_y,
    // extent_along_z from bit 0 up, zero padded
    output logic [((6*COORD_WIDTH-3+7)/8)*8-1:0]  o_m_tdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int TW    = ybef_pkg::TRIG_W;
    localparam int TF    = ybef_pkg::TRIG_FRAC;
    localparam int DW    = CW + 1;
    localparam int PW    = CW + 2;
    localparam int PRW   = DW + TW;
    localparam int MPW   = PW + TW;
    localparam int TSW   = MPW + 1 - TF;
    localparam int SW    = TSW + 1;
    localparam int EW    = CW - 1;
    localparam int OUT_W = ((6*CW-3+7)/8)*8;

    // configuration
    logic signed [CW-1:0] r_center_x, r_center_y, r_center_z;
    logic [TW-1:0]        r_cos_raw, r_sin_raw;
    logic signed [TW-1:0] cos_v, sin_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_cos_raw  <= ybef_pkg::TRIG_ONE;
            r_sin_raw  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ybef_pkg::REG_CENTER_X:   r_center_x <= $signed(i_cfg_data);
                ybef_pkg::REG_CENTER_Y:   r_center_y <= $signed(i_cfg_data);
                ybef_pkg::REG_CENTER_Z:   r_center_z <= $signed(i_cfg_data);
                ybef_pkg::REG_YAW_COSINE: r_cos_raw  <= i_cfg_data[TW-1:0];
                ybef_pkg::REG_YAW_SINE:   r_sin_raw  <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    assign cos_v = ybef_pkg::clamp_trig(r_cos_raw);
    assign sin_v = ybef_pkg::clamp_trig(r_sin_raw);

    // pipeline control
    logic adv;
    logic r_in_valid, r_d_valid, r_p_valid, r_q_valid, r_f_valid, r_m_valid, r_r_valid;
    logic r_in_last, r_d_last, r_p_last, r_q_last;
    logic r_out_valid;

    assign adv        = !(r_out_valid && !i_m_tready && r_r_valid);
    // no transaction is taken while reset is held
    assign o_s_tready = adv && i_rst_n;
    assign o_m_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_d_valid   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_q_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_r_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_in_valid <= i_s_tvalid;
                r_d_valid  <= r_in_valid;
                r_p_valid  <= r_d_valid;
                r_q_valid  <= r_p_valid;
                r_m_valid  <= r_f_valid;
                r_r_valid  <= r_m_valid;
            end
            if (adv && r_r_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input register
    logic signed [CW-1:0] r_px, r_py, r_pz;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px      <= $signed(i_s_tdata[0 +: CW]);
            r_py      <= $signed(i_s_tdata[CW +: CW]);
            r_pz      <= $signed(i_s_tdata[2*CW +: CW]);
            r_in_last <= i_s_tlast;
        end
    end

    // offset from center
    logic signed [DW-1:0] r_dx, r_dy, r_dz;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx     <= DW'(r_px) - DW'(r_center_x);
            r_dy     <= DW'(r_py) - DW'(r_center_y);
            r_dz     <= DW'(r_pz) - DW'(r_center_z);
            r_d_last <= r_in_last;
        end
    end

    // products onto the yawed axes
    logic signed [PRW-1:0] r_pxc, r_pys, r_pyc, r_pxs;
    logic signed [DW-1:0]  r_pdz;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pxc    <= PRW'(r_dx) * PRW'(cos_v);
            r_pys    <= PRW'(r_dy) * PRW'(sin_v);
            r_pyc    <= PRW'(r_dy) * PRW'(cos_v);
            r_pxs    <= PRW'(r_dx) * PRW'(sin_v);
            r_pdz    <= r_dz;
            r_p_last <= r_d_last;
        end
    end

    // projections, floor of sum / 2^14 by bit select
    logic signed [PRW:0]  n_sum_x, n_sum_y;
    logic signed [PW-1:0] r_proj_x, r_proj_y, r_proj_z;

    assign n_sum_x = (PRW+1)'(r_pxc) + (PRW+1)'(r_pys);
    assign n_sum_y = (PRW+1)'(r_pyc) - (PRW+1)'(r_pxs);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_proj_x <= $signed(n_sum_x[TF +: PW]);
            r_proj_y <= $signed(n_sum_y[TF +: PW]);
            r_proj_z <= PW'(r_pdz);
            r_q_last <= r_p_last;
        end
    end

    // running min/max trackers
    localparam logic signed [PW-1:0] PROJ_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [PW-1:0] PROJ_MAX = {1'b0, {(PW-1){1'b1}}};

    logic signed [PW-1:0] r_max_x, r_min_x, r_max_y, r_min_y, r_max_z, r_min_z;
    logic signed [PW-1:0] n_max_x, n_min_x, n_max_y, n_min_y, n_max_z, n_min_z;
    logic signed [PW-1:0] r_fmax_x, r_fmin_x, r_fmax_y, r_fmin_y, r_fmax_z, r_fmin_z;

    assign n_max_x = (r_proj_x > r_max_x) ? r_proj_x : r_max_x;
    assign n_min_x = (r_proj_x < r_min_x) ? r_proj_x : r_min_x;
    assign n_max_y = (r_proj_y > r_max_y) ? r_proj_y : r_max_y;
    assign n_min_y = (r_proj_y < r_min_y) ? r_proj_y : r_min_y;
    assign n_max_z = (r_proj_z > r_max_z) ? r_proj_z : r_max_z;
    assign n_min_z = (r_proj_z < r_min_z) ? r_proj_z : r_min_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x   <= PROJ_MIN;
            r_max_y   <= PROJ_MIN;
            r_max_z   <= PROJ_MIN;
            r_min_x   <= PROJ_MAX;
            r_min_y   <= PROJ_MAX;
            r_min_z   <= PROJ_MAX;
            r_f_valid <= 1'b0;
        end else if (adv) begin
            r_f_valid <= r_q_valid && r_q_last;
            if (r_q_valid && r_q_last) begin
                r_max_x <= PROJ_MIN;
                r_max_y <= PROJ_MIN;
                r_max_z <= PROJ_MIN;
                r_min_x <= PROJ_MAX;
                r_min_y <= PROJ_MAX;
                r_min_z <= PROJ_MAX;
            end else if (r_q_valid) begin
                r_max_x <= n_max_x;
                r_max_y <= n_max_y;
                r_max_z <= n_max_z;
                r_min_x <= n_min_x;
                r_min_y <= n_min_y;
                r_min_z <= n_min_z;
            end
        end
    end

    // snapshot of the finished set, last point included
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fmax_x <= n_max_x;
            r_fmin_x <= n_min_x;
            r_fmax_y <= n_max_y;
            r_fmin_y <= n_min_y;
            r_fmax_z <= n_max_z;
            r_fmin_z <= n_min_z;
        end
    end

    // midpoints and extents
    logic signed [PW:0]   n_msum_x, n_msum_y, n_msum_z;
    logic signed [PW:0]   n_diff_x, n_diff_y, n_diff_z;
    logic signed [PW-1:0] r_mid_x, r_mid_y, r_mid_z;
    logic [EW-1:0]        r_ext_x, r_ext_y, r_ext_z;

    assign n_msum_x = (PW+1)'(r_fmax_x) + (PW+1)'(r_fmin_x);
    assign n_msum_y = (PW+1)'(r_fmax_y) + (PW+1)'(r_fmin_y);
    assign n_msum_z = (PW+1)'(r_fmax_z) + (PW+1)'(r_fmin_z);
    assign n_diff_x = (PW+1)'(r_fmax_x) - (PW+1)'(r_fmin_x);
    assign n_diff_y = (PW+1)'(r_fmax_y) - (PW+1)'(r_fmin_y);
    assign n_diff_z = (PW+1)'(r_fmax_z) - (PW+1)'(r_fmin_z);

    function automatic logic [EW-1:0] sat_extent(input logic signed [PW:0] d);
        if (d[PW]) begin
            return '0;
        end else if (d[PW-1:EW] != '0) begin
            return '1;
        end
        return d[EW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mid_x <= $signed(n_msum_x[PW:1]);
            r_mid_y <= $signed(n_msum_y[PW:1]);
            r_mid_z <= $signed(n_msum_z[PW:1]);
            r_ext_x <= sat_extent(n_diff_x);
            r_ext_y <= sat_extent(n_diff_y);
            r_ext_z <= sat_extent(n_diff_z);
        end
    end

    // rotate the midpoint back to world axes
    logic signed [MPW-1:0] r_mxc, r_mys, r_mxs, r_myc;
    logic signed [PW-1:0]  r_rmz;
    logic [EW-1:0]         r_rext_x, r_rext_y, r_rext_z;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mxc    <= MPW'(r_mid_x) * MPW'(cos_v);
            r_mys    <= MPW'(r_mid_y) * MPW'(sin_v);
            r_mxs    <= MPW'(r_mid_x) * MPW'(sin_v);
            r_myc    <= MPW'(r_mid_y) * MPW'(cos_v);
            r_rmz    <= r_mid_z;
            r_rext_x <= r_ext_x;
            r_rext_y <= r_ext_y;
            r_rext_z <= r_ext_z;
        end
    end

    // new center with saturation
    logic signed [MPW:0]  n_rsum_x, n_rsum_y;
    logic signed [SW-1:0] n_tot_x, n_tot_y, n_tot_z;
    logic signed [CW-1:0] r_ncx, r_ncy, r_ncz;
    logic [EW-1:0]        r_oext_x, r_oext_y, r_oext_z;

    assign n_rsum_x = (MPW+1)'(r_mxc) - (MPW+1)'(r_mys);
    assign n_rsum_y = (MPW+1)'(r_mxs) + (MPW+1)'(r_myc);
    assign n_tot_x  = SW'(r_center_x) + SW'($signed(n_rsum_x[TF +: TSW]));
    assign n_tot_y  = SW'(r_center_y) + SW'($signed(n_rsum_y[TF +: TSW]));
    assign n_tot_z  = SW'(r_center_z) + SW'(r_rmz);

    function automatic logic [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
        if ((v[SW-1:CW-1] == '0) || (v[SW-1:CW-1] == '1)) begin
            return v[CW-1:0];
        end else if (v[SW-1]) begin
            return {1'b1, {(CW-1){1'b0}}};
        end
        return {1'b0, {(CW-1){1'b1}}};
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv && r_r_valid) begin
            r_ncx    <= $signed(sat_coord(n_tot_x));
            r_ncy    <= $signed(sat_coord(n_tot_y));
            r_ncz    <= $signed(sat_coord(n_tot_z));
            r_oext_x <= r_rext_x;
            r_oext_y <= r_rext_y;
            r_oext_z <= r_rext_z;
        end
    end

    assign o_m_tdata = OUT_W'({r_oext_z, r_oext_y, r_oext_x, r_ncz, r_ncy, r_ncx});

endmodule

`default_nettype wire

/* tb/tb_yaw_box_extent_fit_core.sv */
`default_nettype none

module tb_yaw_box_extent_fit_core;
    import ybef_pkg::*;

    localparam int COORD_W = COORD_WIDTH_DEF;
    localparam int S_W = ((3*COORD_W+7)/8)*8;
    localparam int M_W = ((6*COORD_W-3+7)/8)*8;
    localparam int ITEMS = 1750;
    localparam int SETTLE = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 4000;

    localparam longint Q14_ONE = 64'sd1 <<< TRIG_FRAC;
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_W-1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint TRK_HI = (64'sd1 <<< (COORD_W+1)) - 1;
    localparam longint TRK_LO = -TRK_HI - 1;
    localparam logic [COORD_W-1:0] MAXC = COORD_W'(COORD_MAX);
    localparam logic [COORD_W-1:0] MINC = COORD_W'(COORD_MIN);

    typedef struct {
        logic [COORD_W-1:0] cx, cy, cz;
        logic [COORD_W-2:0] ex, ey, ez;
    } box_fit_t;

    class box_refit_checker;
        logic [COORD_W-1:0] ctr_x = '0;
        logic [COORD_W-1:0] ctr_y = '0;
        logic [COORD_W-1:0] ctr_z = '0;
        logic [15:0] cos_raw = 16'd16384;
        logic [15:0] sin_raw = 16'd0;
        longint hi_x = TRK_LO, lo_x = TRK_HI;
        longint hi_y = TRK_LO, lo_y = TRK_HI;
        longint hi_z = TRK_LO, lo_z = TRK_HI;
        box_fit_t pending_fits[$];
        int err_count, points_done, fits_done;

        function void report(string msg);
            if (err_count < 40)
                $display("mismatch at %0t: %s", $realtime, msg);
            err_count++;
        endfunction

        function void set_reg(t_cfg_index idx, logic [COORD_W-1:0] val);
            case (idx)
                REG_CENTER_X: ctr_x = val;
                REG_CENTER_Y: ctr_y = val;
                REG_CENTER_Z: ctr_z = val;
                REG_YAW_COSINE: cos_raw = val[15:0];
                REG_YAW_SINE: sin_raw = val[15:0];
                default: ;
            endcase
        endfunction

        function longint unit_q14(logic [15:0] raw);
            longint v;
            v = longint'($signed(raw));
            if (v > Q14_ONE) v = Q14_ONE;
            else if (v < -Q14_ONE) v = -Q14_ONE;
            return v;
        endfunction

        function logic [COORD_W-1:0] sat_coord(longint v);
            if (v > COORD_MAX) v = COORD_MAX;
            else if (v < COORD_MIN) v = COORD_MIN;
            return v[COORD_W-1:0];
        endfunction

        function logic [COORD_W-2:0] span(longint hi, longint lo);
            longint e;
            e = hi - lo;
            if (e > COORD_MAX) e = COORD_MAX;
            if (e < 0) e = 0;
            return e[COORD_W-2:0];
        endfunction

        // projects one accepted point and, on the last one, predicts the refit box
        function void add_point(logic [COORD_W-1:0] px, py, pz, logic last);
            longint c, s, cx, cy, cz, dx, dy, dz, prj_x, prj_y, mx, my, mz;
            box_fit_t fit;
            c = unit_q14(cos_raw);
            s = unit_q14(sin_raw);
            cx = longint'($signed(ctr_x));
            cy = longint'($signed(ctr_y));
            cz = longint'($signed(ctr_z));
            dx = longint'($signed(px)) - cx;
            dy = longint'($signed(py)) - cy;
            dz = longint'($signed(pz)) - cz;
            prj_x = (dx*c + dy*s) >>> TRIG_FRAC;
            prj_y = (dy*c - dx*s) >>> TRIG_FRAC;
            if (prj_x > hi_x) hi_x = prj_x;
            if (prj_x < lo_x) lo_x = prj_x;
            if (prj_y > hi_y) hi_y = prj_y;
            if (prj_y < lo_y) lo_y = prj_y;
            if (dz > hi_z) hi_z = dz;
            if (dz < lo_z) lo_z = dz;
            points_done++;
            if (!last) return;
            mx = (hi_x + lo_x) >>> 1;
            my = (hi_y + lo_y) >>> 1;
            mz = (hi_z + lo_z) >>> 1;
            fit.cx = sat_coord(cx + ((mx*c - my*s) >>> TRIG_FRAC));
            fit.cy = sat_coord(cy + ((mx*s + my*c) >>> TRIG_FRAC));
            fit.cz = sat_coord(cz + mz);
            fit.ex = span(hi_x, lo_x);
            fit.ey = span(hi_y, lo_y);
            fit.ez = span(hi_z, lo_z);
            pending_fits = {pending_fits, fit};
            hi_x = TRK_LO; lo_x = TRK_HI;
            hi_y = TRK_LO; lo_y = TRK_HI;
            hi_z = TRK_LO; lo_z = TRK_HI;
        endfunction

        function void check_fit(logic [M_W-1:0] d);
            box_fit_t want;
            longint got_v[6], want_v[6];
            string fld[6];
            fld = '{"new_center_x", "new_center_y", "new_center_z",
                    "extent_along_x", "extent_along_y", "extent_along_z"};
            if (pending_fits.size() == 0) begin
                report($sformatf("result with no box pending, data %h", d));
                return;
            end
            want = pending_fits.pop_front();
            got_v[0] = d[COORD_W-1:0];
            got_v[1] = d[2*COORD_W-1:COORD_W];
            got_v[2] = d[3*COORD_W-1:2*COORD_W];
            got_v[3] = d[4*COORD_W-2:3*COORD_W];
            got_v[4] = d[5*COORD_W-3:4*COORD_W-1];
            got_v[5] = d[6*COORD_W-4:5*COORD_W-2];
            want_v = '{want.cx, want.cy, want.cz, want.ex, want.ey, want.ez};
            for (int k = 0; k < 6; k++) begin
                if (got_v[k] != want_v[k])
                    report($sformatf("box %0d %s got %h want %h",
                                     fits_done, fld[k], got_v[k], want_v[k]));
            end
            fits_done++;
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [COORD_W-1:0] i_cfg_data;
    logic i_s_tvalid, o_s_tready;
    // point_x, point_y, point_z from bit 0 up
    logic [S_W-1:0] i_s_tdata;
    logic i_s_tlast;
    logic o_m_tvalid, i_m_tready;
    // new_center_x, new_center_y, new_center_z, extent_along_x, extent_along_y,
    // extent_along_z from bit 0 up
    logic [M_W-1:0] o_m_tdata;

    box_refit_checker refit = new;
    bit tx_gaps, rx_gaps;
    int rx_hold_req, hold_left, stall_left, stuck_cycles;
    int cfg_writes, phase_no, drain_pauses;
    t_cfg_index reg_list[5] = '{REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z,
                                REG_YAW_COSINE, REG_YAW_SINE};

    yaw_box_extent_fit_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            refit.check_fit(o_m_tdata);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d boxes pending",
                         STUCK_LIMIT, refit.pending_fits.size());
                $display("tb_yaw_box_extent_fit_core: errors");
                $finish;
            end
        end
    end

    // output side: random stall bursts, or a long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else if (!rx_gaps) begin
                i_m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 18);
            end
        end
    end

    task automatic write_reg(input t_cfg_index idx, input logic [COORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        refit.set_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic send_point(input logic [COORD_W-1:0] px, py, pz, input logic last);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= S_W'({pz, py, px});
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        refit.add_point(px, py, pz, last);
    endtask

    task automatic drain_fits();
        while (refit.pending_fits.size() != 0) @(posedge i_clk);
    endtask

    // stop offering, wait for every box, then let the pipeline empty out
    task automatic close_phase();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        drain_fits();
        repeat (SETTLE) @(posedge i_clk);
        phase_no++;
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return MAXC;
            1: return MINC;
            2, 3: return $urandom;
            default: return int'($urandom_range(0, 13107200)) - 6553600;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_center();
        case ($urandom_range(0, 5))
            0: return MAXC;
            1: return MINC;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_trig();
        case ($urandom_range(0, 6))
            0: return 16384;
            1: return -16384;
            2: return '0;
            3: return $urandom;
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    initial begin
        t_cfg_index idx;
        int n_sets, set_len;
        bit tail;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: single point, full-range corners, mixed bit patterns
        send_point('0, '0, '0, 1'b1);
        send_point(MAXC, MAXC, MAXC, 1'b0);
        send_point(MINC, MINC, MINC, 1'b1);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 1'b0);
        send_point(32'hAAAA_AAAA, 32'h5555_5555, -7, 1'b0);
        send_point(1, -1, '0, 1'b1);
        close_phase();

        // center at the top corner, reversed axes: new center saturates low
        write_reg(REG_CENTER_X, MAXC);
        write_reg(REG_CENTER_Y, MAXC);
        write_reg(REG_CENTER_Z, MAXC);
        write_reg(REG_YAW_COSINE, -16384);
        write_reg(REG_YAW_SINE, 16384);
        send_point(MINC, MINC, MINC, 1'b1);
        send_point(MAXC, MINC, '0, 1'b0);
        send_point(MINC, MAXC, MAXC, 1'b1);
        close_phase();

        // trig registers beyond one clamp, upper write bits ignored
        write_reg(REG_CENTER_X, MINC);
        write_reg(REG_CENTER_Y, MINC);
        write_reg(REG_CENTER_Z, MINC);
        write_reg(REG_YAW_COSINE, 32'hFFFF_7FFF);
        write_reg(REG_YAW_SINE, 32'h0000_8000);
        send_point(MAXC, MAXC, MAXC, 1'b1);
        send_point(MAXC, MINC, MAXC, 1'b0);
        send_point('0, MAXC, MINC, 1'b0);
        send_point(32'h0001_0000, 32'hFFFF_0000, '0, 1'b1);
        close_phase();

        // quarter turn, then a non-unit axis pair
        write_reg(REG_CENTER_X, '0);
        write_reg(REG_CENTER_Y, '0);
        write_reg(REG_CENTER_Z, '0);
        write_reg(REG_YAW_COSINE, '0);
        write_reg(REG_YAW_SINE, 16384);
        repeat (3) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        send_point(32'h0003_8000, -32'sh0002_4000, 32'h0000_0001, 1'b1);
        // let the quarter-turn box leave before the axes change
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        drain_fits();
        repeat (SETTLE) @(posedge i_clk);
        write_reg(REG_YAW_COSINE, 16384);
        send_point(32'h7FFF_0000, 32'h7FFF_0000, 32'h8000_0000, 1'b1);
        close_phase();

        while (refit.points_done < ITEMS) begin
            tail = (refit.points_done >= ITEMS - 250);
            repeat ($urandom_range(1, 5)) begin
                idx = reg_list[$urandom_range(0, 4)];
                if (idx == REG_YAW_COSINE || idx == REG_YAW_SINE)
                    write_reg(idx, pick_trig());
                else
                    write_reg(idx, pick_center());
            end
            tx_gaps = !tail && ($urandom_range(0, 3) != 0);
            rx_gaps = !tail && ($urandom_range(0, 3) != 0);
            if (phase_no == 6) begin
                // output held off while single-point sets keep coming
                tx_gaps = 1'b0;
                rx_hold_req = HOLD_CYCLES;
                repeat (60) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
            end else begin
                n_sets = $urandom_range(8, 30);
                for (int s = 0; s < n_sets; s++) begin
                    set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                          : $urandom_range(1, 6);
                    for (int j = 0; j < set_len; j++)
                        send_point(rand_coord(), rand_coord(), rand_coord(),
                                   j == set_len - 1);
                    if (phase_no == 8 && s == n_sets / 2) begin
                        @(negedge i_clk);
                        i_s_tvalid <= 1'b0;
                        drain_fits();
                        drain_pauses++;
                    end
                end
            end
            close_phase();
        end

        $display("%0d points in %0d fitted boxes over %0d phases, %0d register writes",
                 refit.points_done, refit.fits_done, phase_no, cfg_writes);
        $display("covered corners, clamped trig, saturation, a %0d-cycle hold-off, %0d drain(s)",
                 HOLD_CYCLES, drain_pauses);
        if (refit.err_count == 0)
            $display("tb_yaw_box_extent_fit_core: clean");
        else
            $display("tb_yaw_box_extent_fit_core: errors");
        $finish;
    end

endmodule

`default_nettype wire

/* yaw_box_extent_fit_core.f */
sv/ybef_pkg.sv
sv/yaw_box_extent_fit_core.sv
tb/tb_yaw_box_extent_fit_core.sv
